// ===== design/fnvlp_pkg.sv =====
`default_nettype none
package fnvlp_pkg;

	localparam int HOME_W = 12;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_LOOKUP = 3'd1;
	localparam logic [2:0] CMD_REMOVE = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_MISSING    = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;
	localparam logic [1:0] ST_EMPTY_SLOT = 2'd3;

	localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
	localparam logic [8:0]  PRIME_LOW  = 9'h1b3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] key;
		logic [63:0] value;
		logic [4:0]  slot;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] found_key;
		logic [63:0] found_value;
		logic [5:0]  live_count;
	} rsp_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [63:0]       key;
		logic [63:0]       value;
		logic [4:0]        slot;
		logic [HOME_W-1:0] home;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_FCHK,
		B_FBT,
		B_FENT,
		B_RBCLR,
		B_RBNEXT,
		B_RBHOME,
		B_RBPROBE,
		B_SRD,
		B_SRDW,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

// ===== design/fnvlp_front.sv =====
`default_nettype none
module fnvlp_front #(
	parameter int BUCKETS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire fnvlp_pkg::req_t req,
	output logic                push_valid,
	input  wire logic           push_full,
	output fnvlp_pkg::job_t     push_data
);

	localparam int  BW   = $clog2(BUCKETS);
	localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	fnvlp_pkg::front_state_t st_q, st_nxt;
	fnvlp_pkg::req_t         item_q;
	logic [63:0]             h_q;
	logic [63:0]             ksh_q;
	logic [5:0]              cnt_q;
	logic [BW-1:0]           r_q;

	logic [63:0] x;
	logic [63:0] h_step;
	logic [BW:0] t;
	logic [BW:0] r_red;
	logic [BW-1:0] home;

	// multiply by the prime as (x << 40) + x * 0x1b3
	assign x      = h_q ^ {56'd0, ksh_q[7:0]};
	assign h_step = (x << 40) + (x * {55'd0, fnvlp_pkg::PRIME_LOW});
	assign t      = {r_q, h_q[63]};
	assign r_red  = (t >= (BW + 1)'(BUCKETS)) ? t - (BW + 1)'(BUCKETS) : t;
	assign home   = POW2 ? h_q[BW-1:0] : r_q;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			fnvlp_pkg::F_IDLE: if (req_valid) st_nxt = fnvlp_pkg::F_HASH;
			fnvlp_pkg::F_HASH: begin
				if (cnt_q == 6'd7) st_nxt = POW2 ? fnvlp_pkg::F_PUSH : fnvlp_pkg::F_MOD;
			end
			fnvlp_pkg::F_MOD: if (cnt_q == 6'd63) st_nxt = fnvlp_pkg::F_PUSH;
			fnvlp_pkg::F_PUSH: if (!push_full) st_nxt = fnvlp_pkg::F_IDLE;
			default: st_nxt = fnvlp_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = (st_q != fnvlp_pkg::F_IDLE);
		push_valid = (st_q == fnvlp_pkg::F_PUSH);
		push_data.cmd   = item_q.cmd;
		push_data.key   = item_q.key;
		push_data.value = item_q.value;
		push_data.slot  = item_q.slot;
		push_data.home  = fnvlp_pkg::HOME_W'(home);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= fnvlp_pkg::F_IDLE;
		else st_q <= st_nxt;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			fnvlp_pkg::F_IDLE: begin
				item_q <= req;
				h_q    <= fnvlp_pkg::HASH_BASIS;
				ksh_q  <= req.key;
				cnt_q  <= '0;
			end
			fnvlp_pkg::F_HASH: begin
				h_q   <= h_step;
				ksh_q <= ksh_q >> 8;
				cnt_q <= (cnt_q == 6'd7) ? 6'd0 : cnt_q + 6'd1;
				r_q   <= '0;
			end
			fnvlp_pkg::F_MOD: begin
				// reduce one hash bit per cycle, most significant first
				r_q   <= r_red[BW-1:0];
				h_q   <= h_q << 1;
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/fnvlp_queue.sv =====
`default_nettype none
module fnvlp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fnvlp_pkg::job_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output logic                 q_valid,
	output fnvlp_pkg::job_t      q_data
);

	fnvlp_pkg::job_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== design/fnvlp_back.sv =====
`default_nettype none
module fnvlp_back #(
	parameter int ENTRIES = 32,
	parameter int BUCKETS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire fnvlp_pkg::job_t q_data,
	output logic                 pop,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output fnvlp_pkg::rsp_t      rsp
);

	localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int BW  = $clog2(BUCKETS);
	localparam int PW  = $clog2(BUCKETS + 1);
	localparam int SXW = CW + 5;

	fnvlp_pkg::back_state_t state_q, state_nxt;
	fnvlp_pkg::job_t        job_q;
	fnvlp_pkg::rsp_t        res_q, rsp_q;
	logic                   rsp_valid_q;
	logic [BW-1:0]          b_q;
	logic [PW-1:0]          pc_q;
	logic [CW-1:0]          e_q;
	logic [CW-1:0]          hw_q;
	logic [CW-1:0]          live_tot_q;
	logic [ENTRIES-1:0]     live_q;
	logic [BUCKETS-1:0]     bvalid_q;

	logic [63:0]   ekey_mem [ENTRIES];
	logic [63:0]   eval_mem [ENTRIES];
	logic [BW-1:0] ehome_mem [ENTRIES];
	logic [EW-1:0] btab_mem [BUCKETS];
	logic [63:0]   ekey_rd, eval_rd;
	logic [BW-1:0] ehome_rd;
	logic [EW-1:0] bt_rd;

	logic          key_we, val_we, home_we, bt_we;
	logic [EW-1:0] w_addr, ent_raddr, bt_wdata;
	logic [BW-1:0] bt_waddr, bt_raddr;

	logic [BW-1:0]  b_next;
	logic [EW-1:0]  e_idx;
	logic [SXW-1:0] slot_x;
	logic           probe_end, b_free, fchk_miss, has_room, ins_ok, hit, out_free;

	assign b_next    = (b_q == BW'(BUCKETS - 1)) ? '0 : b_q + 1'b1;
	assign e_idx     = e_q[EW-1:0];
	assign slot_x    = SXW'(job_q.slot);
	assign probe_end = (pc_q == PW'(BUCKETS));
	assign b_free    = !bvalid_q[b_q];
	assign fchk_miss = probe_end || b_free;
	assign has_room  = (hw_q < CW'(ENTRIES));
	assign ins_ok    = !probe_end && b_free && has_room;
	assign hit       = live_q[e_idx] && (ekey_rd == job_q.key);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign pop       = (state_q == fnvlp_pkg::B_IDLE) && q_valid;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fnvlp_pkg::B_IDLE: begin
				if (q_valid) begin
					case (q_data.cmd) inside
						fnvlp_pkg::CMD_INSERT, fnvlp_pkg::CMD_LOOKUP,
						fnvlp_pkg::CMD_REMOVE: state_nxt = fnvlp_pkg::B_FCHK;
						fnvlp_pkg::CMD_READ: state_nxt = fnvlp_pkg::B_SRD;
						default: state_nxt = fnvlp_pkg::B_DONE;
					endcase
				end
			end
			fnvlp_pkg::B_FCHK: state_nxt = fchk_miss ? fnvlp_pkg::B_DONE : fnvlp_pkg::B_FBT;
			fnvlp_pkg::B_FBT: state_nxt = fnvlp_pkg::B_FENT;
			fnvlp_pkg::B_FENT: begin
				if (!hit) state_nxt = fnvlp_pkg::B_FCHK;
				else if (job_q.cmd == fnvlp_pkg::CMD_REMOVE) state_nxt = fnvlp_pkg::B_RBCLR;
				else state_nxt = fnvlp_pkg::B_DONE;
			end
			fnvlp_pkg::B_RBCLR: state_nxt = fnvlp_pkg::B_RBNEXT;
			fnvlp_pkg::B_RBNEXT: begin
				if (e_q >= hw_q) state_nxt = fnvlp_pkg::B_DONE;
				else if (live_q[e_idx]) state_nxt = fnvlp_pkg::B_RBHOME;
			end
			fnvlp_pkg::B_RBHOME: state_nxt = fnvlp_pkg::B_RBPROBE;
			fnvlp_pkg::B_RBPROBE: if (probe_end || b_free) state_nxt = fnvlp_pkg::B_RBNEXT;
			fnvlp_pkg::B_SRD: state_nxt = fnvlp_pkg::B_SRDW;
			fnvlp_pkg::B_SRDW: state_nxt = fnvlp_pkg::B_DONE;
			fnvlp_pkg::B_DONE: if (out_free) state_nxt = fnvlp_pkg::B_IDLE;
			default: state_nxt = fnvlp_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		key_we    = 1'b0;
		val_we    = 1'b0;
		home_we   = 1'b0;
		bt_we     = 1'b0;
		w_addr    = e_idx;
		bt_waddr  = b_q;
		bt_wdata  = e_idx;
		bt_raddr  = b_q;
		ent_raddr = e_idx;
		unique case (state_q)
			fnvlp_pkg::B_FCHK: begin
				if (job_q.cmd == fnvlp_pkg::CMD_INSERT && ins_ok) begin
					key_we   = 1'b1;
					val_we   = 1'b1;
					home_we  = 1'b1;
					bt_we    = 1'b1;
					w_addr   = hw_q[EW-1:0];
					bt_wdata = hw_q[EW-1:0];
				end
			end
			fnvlp_pkg::B_FBT: ent_raddr = bt_rd;
			fnvlp_pkg::B_FENT: val_we = hit && (job_q.cmd == fnvlp_pkg::CMD_INSERT);
			fnvlp_pkg::B_RBPROBE: bt_we = !probe_end && b_free;
			fnvlp_pkg::B_SRD: ent_raddr = slot_x[EW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) ekey_mem[w_addr] <= job_q.key;
		if (val_we) eval_mem[w_addr] <= job_q.value;
		if (home_we) ehome_mem[w_addr] <= job_q.home[BW-1:0];
		ekey_rd  <= ekey_mem[ent_raddr];
		eval_rd  <= eval_mem[ent_raddr];
		ehome_rd <= ehome_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (bt_we) btab_mem[bt_waddr] <= bt_wdata;
		bt_rd <= btab_mem[bt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fnvlp_pkg::B_IDLE;
			rsp_valid_q <= 1'b0;
			hw_q        <= '0;
			live_tot_q  <= '0;
			live_q      <= '0;
			bvalid_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == fnvlp_pkg::B_DONE && out_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				fnvlp_pkg::B_IDLE: begin
					if (q_valid && q_data.cmd == fnvlp_pkg::CMD_CLEAR) begin
						hw_q       <= '0;
						live_tot_q <= '0;
						live_q     <= '0;
						bvalid_q   <= '0;
					end
				end
				fnvlp_pkg::B_FCHK: begin
					if (job_q.cmd == fnvlp_pkg::CMD_INSERT && ins_ok) begin
						live_q[hw_q[EW-1:0]] <= 1'b1;
						bvalid_q[b_q]        <= 1'b1;
						hw_q                 <= hw_q + 1'b1;
						live_tot_q           <= live_tot_q + 1'b1;
					end
				end
				fnvlp_pkg::B_FENT: begin
					if (hit && job_q.cmd == fnvlp_pkg::CMD_REMOVE) begin
						live_q[e_idx] <= 1'b0;
						live_tot_q    <= live_tot_q - 1'b1;
					end
				end
				fnvlp_pkg::B_RBCLR: bvalid_q <= '0;
				fnvlp_pkg::B_RBPROBE: if (!probe_end && b_free) bvalid_q[b_q] <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fnvlp_pkg::B_IDLE: begin
				job_q  <= q_data;
				b_q    <= q_data.home[BW-1:0];
				pc_q   <= '0;
				res_q  <= '{fnvlp_pkg::ST_OK, 64'd0, 64'd0, 6'd0};
			end
			fnvlp_pkg::B_FCHK: begin
				if (fchk_miss) begin
					if (job_q.cmd != fnvlp_pkg::CMD_INSERT) res_q.status <= fnvlp_pkg::ST_MISSING;
					else if (!ins_ok) res_q.status <= fnvlp_pkg::ST_FULL;
				end
			end
			fnvlp_pkg::B_FBT: e_q <= CW'(bt_rd);
			fnvlp_pkg::B_FENT: begin
				if (hit) begin
					if (job_q.cmd == fnvlp_pkg::CMD_LOOKUP) res_q.found_value <= eval_rd;
				end else begin
					b_q  <= b_next;
					pc_q <= pc_q + 1'b1;
				end
			end
			fnvlp_pkg::B_RBCLR: e_q <= '0;
			fnvlp_pkg::B_RBNEXT: if (e_q < hw_q && !live_q[e_idx]) e_q <= e_q + 1'b1;
			fnvlp_pkg::B_RBHOME: begin
				b_q  <= ehome_rd;
				pc_q <= '0;
			end
			fnvlp_pkg::B_RBPROBE: begin
				if (probe_end || b_free) begin
					e_q <= e_q + 1'b1;
				end else begin
					b_q  <= b_next;
					pc_q <= pc_q + 1'b1;
				end
			end
			fnvlp_pkg::B_SRD: begin
				if (!(slot_x < SXW'(hw_q) && live_q[slot_x[EW-1:0]]))
					res_q.status <= fnvlp_pkg::ST_EMPTY_SLOT;
			end
			fnvlp_pkg::B_SRDW: begin
				if (res_q.status == fnvlp_pkg::ST_OK) begin
					res_q.found_key   <= ekey_rd;
					res_q.found_value <= eval_rd;
				end
			end
			fnvlp_pkg::B_DONE: begin
				if (out_free) begin
					rsp_q            <= res_q;
					rsp_q.live_count <= 6'(live_tot_q);
				end
			end
			default: ;
		endcase
	end

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CW'(ENTRIES)) else $error("high-water beyond capacity");

	a_live_le_hw: assert property (@(posedge clk) disable iff (!arst_n)
		live_tot_q <= hw_q) else $error("live count above high-water");

	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fnvlp_pkg::B_IDLE && q_valid) |=> (state_q != fnvlp_pkg::B_IDLE))
		else $error("item popped but not dispatched");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fnvlp_pkg::B_DONE && job_q.cmd == fnvlp_pkg::CMD_CLEAR) |->
		(live_tot_q == '0 && bvalid_q == '0)) else $error("clear left state behind");

endmodule
`default_nettype wire

// ===== design/fnv_linear_probe_hash_map_core.sv =====
// Key-value map, 64-bit keys and values, open addressing with linear probing.
// Request channel req/req_valid/req_stall carries one command item; response
// channel rsp/rsp_valid/rsp_stall returns exactly one result item per command.
// The front hashes the key (FNV-1a 64, eight multiply steps, one per cycle),
// plus a reduction of one hash bit per cycle for the bucket index when BUCKETS
// is not a power of two, and hands the item to a two-deep queue.
// req_stall is high from the accepting edge until the front hands its item over,
// so the front takes no new item before the last one has left for the queue.
// On lookup, insert and remove the back visits each occupied bucket of the probe
// with a check, a bucket table read and an entry read, and ends the walk at a hit,
// at an empty bucket or when every bucket has been probed; read entry reads the
// slot and registers it, and clear goes straight to the response. Remove then
// clears all bucket valid bits and re-inserts each live entry at the first free
// bucket from its home. The front takes a new item while the back works on older ones.
// Reset empties the map: live marks, bucket valid bits and counts are cleared
// at once; no clearing pass is needed.
// While rsp_stall is high the response holds; the back then finishes its
// current item and waits, the queue fills and the front holds its item.
`default_nettype none
module fnv_linear_probe_hash_map_core #(
	parameter int ENTRIES = 32,
	parameter int BUCKETS = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire fnvlp_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output fnvlp_pkg::rsp_t      rsp
);

	logic            push_valid, push_full, pop, q_valid;
	fnvlp_pkg::job_t push_data, q_data;

	fnvlp_front #(.BUCKETS(BUCKETS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push_valid(push_valid),
		.push_full (push_full),
		.push_data (push_data)
	);

	fnvlp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_data(push_data),
		.full     (push_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	fnvlp_back #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
